[rtl/ezr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_pkg: shared constants and types of the Euler ZYZ vector rotation
// Number formats, the arc tangent table and the item carried through the
// three CORDIC rotators.
// ----------------------------------------------------------------------------
package ezr_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_WIDTH     = 16;
    localparam int ROTATION_STAGES = 16;
    localparam int GUARD_BITS      = 8;

    // Stages beyond the arc tangent table add nothing.
    localparam int CORDIC_STAGES = (ROTATION_STAGES < 32) ? ROTATION_STAGES : 32;

    // Working width: coordinate, guard fraction and headroom for CORDIC gain.
    localparam int INT_WIDTH  = COORD_WIDTH + GUARD_BITS + 4;
    localparam int LO_WIDTH   = 32;
    localparam int MAG_WIDTH  = (INT_WIDTH - 1 > LO_WIDTH + 1) ? INT_WIDTH - 1 : LO_WIDTH + 1;
    localparam int HI_WIDTH   = MAG_WIDTH - LO_WIDTH;
    localparam int TURN_WIDTH = 32;
    localparam int Z_WIDTH    = TURN_WIDTH + 1;

    // Infinite-stage CORDIC gain 0.60725293500888 in Q0.32.
    localparam logic [LO_WIDTH-1:0] GAIN_Q32 = 32'h9B74EDA8;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
    localparam logic [TURN_WIDTH-1:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Payload that rides along a rotator: the untouched coordinate and the
    // angles of the rotations still to come.
    typedef struct packed {
        logic [INT_WIDTH-1:0]   w;
        logic [ANGLE_WIDTH-1:0] angle_a;
        logic [ANGLE_WIDTH-1:0] angle_b;
    } side_t;

    // One request entering or leaving a rotator: the pair (u, v) is rotated
    // counter-clockwise by angle.
    typedef struct packed {
        logic [INT_WIDTH-1:0]   u;
        logic [INT_WIDTH-1:0]   v;
        logic [ANGLE_WIDTH-1:0] angle;
        side_t                  side;
    } rot_item_t;

endpackage
`default_nettype wire

[rtl/ezr_rotator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_rotator: pipelined plane rotation
// Quadrant pre-rotation, one CORDIC iteration per stage and a four-stage
// gain compensation. All stages advance together on en.
// ----------------------------------------------------------------------------
module ezr_rotator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire ezr_pkg::rot_item_t in_item,
    output logic                   out_valid,
    output ezr_pkg::rot_item_t     out_item
);

    localparam int NS   = ezr_pkg::CORDIC_STAGES;
    localparam int IW   = ezr_pkg::INT_WIDTH;
    localparam int MW   = ezr_pkg::MAG_WIDTH;
    localparam int LW   = ezr_pkg::LO_WIDTH;
    localparam int HW   = ezr_pkg::HI_WIDTH;
    localparam int AW   = ezr_pkg::ANGLE_WIDTH;
    localparam int TW   = ezr_pkg::TURN_WIDTH;
    localparam int ZW   = ezr_pkg::Z_WIDTH;
    localparam int LAST = NS + 4;

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'd1 << (TW - 2));

    // Stage 0 holds the pre-rotated pair, stage i+1 the pair after iteration i.
    logic [LAST:0]            vld_reg;
    ezr_pkg::side_t           side_reg  [0:LAST];
    logic signed [IW-1:0]     cord_reg  [0:NS][2];
    logic signed [IW-1:0]     cord_next [0:NS][2];
    logic signed [ZW-1:0]     z_reg     [0:NS];
    logic signed [ZW-1:0]     z_next    [0:NS];

    // Gain compensation stages, one entry per lane.
    logic                     neg1_reg  [2];
    logic [MW-1:0]            mag_reg   [2];
    logic                     neg2_reg  [2];
    logic [2*LW-1:0]          lo_reg    [2];
    logic [HW+LW-1:0]         hi_reg    [2];
    logic                     neg3_reg  [2];
    logic [MW-1:0]            rmag_reg  [2];
    logic signed [IW-1:0]     res_reg   [2];

    logic [MW-1:0]            mag_next  [2];
    logic [2*LW-1:0]          lo_next   [2];
    logic [HW+LW-1:0]         hi_next   [2];
    logic [MW-1:0]            rmag_next [2];
    logic signed [IW-1:0]     res_next  [2];

    logic [TW-1:0]            turn;
    logic [1:0]               quad;
    logic signed [IW-1:0]     in_u;
    logic signed [IW-1:0]     in_v;
    logic signed [IW-1:0]     pre_u;
    logic signed [IW-1:0]     pre_v;
    logic signed [ZW-1:0]     pre_z;

    // The residual angle is brought into [-1/8, 1/8) turn, the quadrant
    // absorbing the rest.
    always_comb
    begin
        turn         = TW'(in_item.angle) << (TW - AW);
        quad         = turn[TW-1:TW-2] + {1'b0, turn[TW-3]};
        pre_z        = $signed({{(ZW-TW+2){1'b0}}, turn[TW-3:0]})
                       - (turn[TW-3] ? Z_QUARTER : '0);
        in_u         = $signed(in_item.u);
        in_v         = $signed(in_item.v);
        case (quad)
            QUAD_0:
            begin
                pre_u = in_u;
                pre_v = in_v;
            end
            QUAD_90:
            begin
                pre_u = -in_v;
                pre_v = in_u;
            end
            QUAD_180:
            begin
                pre_u = -in_u;
                pre_v = -in_v;
            end
            QUAD_270:
            begin
                pre_u = in_v;
                pre_v = -in_u;
            end
            default:
            begin
                pre_u = in_u;
                pre_v = in_v;
            end
        endcase
    end

    assign cord_next[0][0] = pre_u;
    assign cord_next[0][1] = pre_v;
    assign z_next[0]       = pre_z;

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN_I = $signed({1'b0, ezr_pkg::ATAN_TURN[i]});
        logic signed [IW-1:0] du;
        logic signed [IW-1:0] dv;
        assign du = cord_reg[i][1] >>> i;
        assign dv = cord_reg[i][0] >>> i;
        assign cord_next[i+1][0] = z_reg[i][ZW-1] ? cord_reg[i][0] + du
                                                  : cord_reg[i][0] - du;
        assign cord_next[i+1][1] = z_reg[i][ZW-1] ? cord_reg[i][1] - dv
                                                  : cord_reg[i][1] + dv;
        assign z_next[i+1]       = z_reg[i][ZW-1] ? z_reg[i] + ATAN_I
                                                  : z_reg[i] - ATAN_I;
    end

    // Gain: magnitude, split multiply, round half away from zero, sign.
    for (genvar l = 0; l < 2; l++) begin : g_gain
        logic signed [IW-1:0] neg_val;
        assign neg_val      = -cord_reg[NS][l];
        assign mag_next[l]  = cord_reg[NS][l][IW-1] ? MW'(neg_val) : MW'(cord_reg[NS][l]);
        assign lo_next[l]   = (2*LW)'(mag_reg[l][LW-1:0]) * (2*LW)'(ezr_pkg::GAIN_Q32);
        assign hi_next[l]   = (HW+LW)'(mag_reg[l][MW-1:LW]) * (HW+LW)'(ezr_pkg::GAIN_Q32);
        assign rmag_next[l] = MW'(hi_reg[l]) + MW'(lo_reg[l][2*LW-1:LW])
                              + MW'(lo_reg[l][LW-1]);
        assign res_next[l]  = neg3_reg[l] ? -$signed(IW'(rmag_reg[l]))
                                          : $signed(IW'(rmag_reg[l]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_item.side;
            for (int s = 1; s <= LAST; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            for (int s = 0; s <= NS; s++)
            begin
                cord_reg[s][0] <= cord_next[s][0];
                cord_reg[s][1] <= cord_next[s][1];
                z_reg[s]       <= z_next[s];
            end
            for (int l = 0; l < 2; l++)
            begin
                neg1_reg[l] <= cord_reg[NS][l][IW-1];
                mag_reg[l]  <= mag_next[l];
                neg2_reg[l] <= neg1_reg[l];
                lo_reg[l]   <= lo_next[l];
                hi_reg[l]   <= hi_next[l];
                neg3_reg[l] <= neg2_reg[l];
                rmag_reg[l] <= rmag_next[l];
                res_reg[l]  <= res_next[l];
            end
        end
    end

    assign out_valid      = vld_reg[LAST];
    assign out_item.u     = res_reg[0];
    assign out_item.v     = res_reg[1];
    assign out_item.angle = '0;
    assign out_item.side  = side_reg[LAST];

endmodule
`default_nettype wire

[rtl/euler_zyz_vector_rotation.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_zyz_vector_rotation: fixed-point Euler ZYZ rotation of a 3D vector
// Rotates a vector about Z by psi, about Y by theta and about Z by phi with
// three pipelined CORDIC rotators, then rounds and saturates the result.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Width  Contents (lowest bits first)
//  s_axis    in         120    vec_x, vec_y, vec_z, angle_phi, angle_theta,
//                              angle_psi
//  m_axis    out        72+1   tdata: out_x, out_y, out_z; tuser: saturated
//
//  One request enters per clock cycle while m_axis does not stall; each
//  passes the three rotators and then the output register.
//  Reset clears only the valid bits of the pipeline; no clearing pass follows.
//  A stall on m_axis freezes the whole pipeline while the output register is
//  full; an empty output register lets the pipeline keep moving, so requests
//  are still accepted while bubbles remain downstream.
//
module euler_zyz_vector_rotation (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // vec_x[23:0], vec_y[47:24], vec_z[71:48], angle_phi[87:72],
    // angle_theta[103:88], angle_psi[119:104]
    input  wire logic [119:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // out_x[23:0], out_y[47:24], out_z[71:48]
    output logic [71:0]        m_axis_tdata,
    // saturated[0]
    output logic [0:0]         m_axis_tuser
);

    localparam int CW = ezr_pkg::COORD_WIDTH;
    localparam int AW = ezr_pkg::ANGLE_WIDTH;
    localparam int GB = ezr_pkg::GUARD_BITS;
    localparam int IW = ezr_pkg::INT_WIDTH;
    localparam int RW = IW - GB;

    logic                  en;
    logic [CW-1:0]         vec_x;
    logic [CW-1:0]         vec_y;
    logic [CW-1:0]         vec_z;
    logic [AW-1:0]         angle_phi;
    logic [AW-1:0]         angle_theta;
    logic [AW-1:0]         angle_psi;

    ezr_pkg::rot_item_t    rot1_in;
    ezr_pkg::rot_item_t    rot1_out;
    ezr_pkg::rot_item_t    rot2_in;
    ezr_pkg::rot_item_t    rot2_out;
    ezr_pkg::rot_item_t    rot3_in;
    ezr_pkg::rot_item_t    rot3_out;
    logic                  rot1_valid;
    logic                  rot2_valid;
    logic                  rot3_valid;

    logic [CW:0]           fin_x;
    logic [CW:0]           fin_y;
    logic [CW:0]           fin_z;

    logic                  out_valid_reg;
    logic [CW-1:0]         out_x_reg;
    logic [CW-1:0]         out_y_reg;
    logic [CW-1:0]         out_z_reg;
    logic                  saturated_reg;

    // Coordinate into the working format: sign extension and guard fraction.
    function automatic logic [IW-1:0] widen(input logic [CW-1:0] c);
        widen = {{(IW-CW-GB){c[CW-1]}}, c, {GB{1'b0}}};
    endfunction

    // Round half up to an integer and clip to the coordinate range.
    // Returns the clip flag above the clipped value.
    function automatic logic [CW:0] finish(input logic [IW-1:0] v);
        logic signed [IW-1:0] sum;
        logic signed [RW-1:0] r;
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        sum = $signed(v) + $signed(IW'(1) << (GB - 1));
        r   = sum[IW-1:GB];
        hi  = $signed({{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}});
        lo  = $signed({{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}});
        if (r > hi)
        begin
            finish = {1'b1, hi[CW-1:0]};
        end
        else if (r < lo)
        begin
            finish = {1'b1, lo[CW-1:0]};
        end
        else
        begin
            finish = {1'b0, r[CW-1:0]};
        end
    endfunction

    // The whole pipeline moves unless a finished result is waiting.
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign vec_x       = s_axis_tdata[CW-1:0];
    assign vec_y       = s_axis_tdata[2*CW-1:CW];
    assign vec_z       = s_axis_tdata[3*CW-1:2*CW];
    assign angle_phi   = s_axis_tdata[3*CW+AW-1:3*CW];
    assign angle_theta = s_axis_tdata[3*CW+2*AW-1:3*CW+AW];
    assign angle_psi   = s_axis_tdata[3*CW+3*AW-1:3*CW+2*AW];

    // First rotation: (x, y) about Z by psi; z and the later angles ride along.
    assign rot1_in.u            = widen(vec_x);
    assign rot1_in.v            = widen(vec_y);
    assign rot1_in.angle        = angle_psi;
    assign rot1_in.side.w       = widen(vec_z);
    assign rot1_in.side.angle_a = angle_theta;
    assign rot1_in.side.angle_b = angle_phi;

    ezr_rotator u_rot_psi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_item   (rot1_in),
        .out_valid (rot1_valid),
        .out_item  (rot1_out)
    );

    // Second rotation: (z, x) about Y by theta, which gives x' = c*x + s*z
    // and z' = -s*x + c*z; y rides along.
    assign rot2_in.u            = rot1_out.side.w;
    assign rot2_in.v            = rot1_out.u;
    assign rot2_in.angle        = rot1_out.side.angle_a;
    assign rot2_in.side.w       = rot1_out.v;
    assign rot2_in.side.angle_a = rot1_out.side.angle_b;
    assign rot2_in.side.angle_b = '0;

    ezr_rotator u_rot_theta (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot1_valid),
        .in_item   (rot2_in),
        .out_valid (rot2_valid),
        .out_item  (rot2_out)
    );

    // Third rotation: (x, y) about Z by phi; z rides along.
    assign rot3_in.u            = rot2_out.v;
    assign rot3_in.v            = rot2_out.side.w;
    assign rot3_in.angle        = rot2_out.side.angle_a;
    assign rot3_in.side.w       = rot2_out.u;
    assign rot3_in.side.angle_a = '0;
    assign rot3_in.side.angle_b = '0;

    ezr_rotator u_rot_phi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot2_valid),
        .in_item   (rot3_in),
        .out_valid (rot3_valid),
        .out_item  (rot3_out)
    );

    assign fin_x = finish(rot3_out.u);
    assign fin_y = finish(rot3_out.v);
    assign fin_z = finish(rot3_out.side.w);

    // Output register, also the last pipeline stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rot3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg     <= fin_x[CW-1:0];
            out_y_reg     <= fin_y[CW-1:0];
            out_z_reg     <= fin_z[CW-1:0];
            saturated_reg <= fin_x[CW] | fin_y[CW] | fin_z[CW];
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_z_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser[0] = saturated_reg;

endmodule
`default_nettype wire

[rtl/ezr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_checker: port-level checks of the Euler ZYZ vector rotation
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ezr_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          s_axis_tready,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [71:0]   m_axis_tdata,
    input wire logic [0:0]    m_axis_tuser
);

    localparam int CW = ezr_pkg::COORD_WIDTH;
    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // A result that is not taken stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

    // Requests are taken exactly when the output register can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output register state");

    // A clipped result has at least one component at a bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[CW-1:0] == COORD_MAX || m_axis_tdata[CW-1:0] == COORD_MIN ||
            m_axis_tdata[2*CW-1:CW] == COORD_MAX || m_axis_tdata[2*CW-1:CW] == COORD_MIN ||
            m_axis_tdata[3*CW-1:2*CW] == COORD_MAX || m_axis_tdata[3*CW-1:2*CW] == COORD_MIN)
    else $error("saturation flag without a clipped component");

endmodule

bind euler_zyz_vector_rotation ezr_checker u_ezr_checker (.*);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Euler ZYZ vector rotation
// Streams vectors and angle triples into the rotator, predicts results with a
// bit-exact fixed-point CORDIC model or a directed row, then checks each field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW = ezr_pkg::COORD_WIDTH;
    localparam int AW = ezr_pkg::ANGLE_WIDTH;

    // Turn fractions used by the quadrant pre-rotation.
    localparam longint EIGHTH_TURN  = 64'h2000_0000;
    localparam longint QUARTER_TURN = 64'h4000_0000;

    // Output range and the rounding offset of the guard fraction.
    localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint HALF_LSB  = 64'sd1 <<< (ezr_pkg::GUARD_BITS - 1);

    // The pipeline is 64 deep with sixteen stages; leave margin after drain.
    localparam int     DRAIN_CYCLES    = 100;
    localparam int     RANDOM_REQUESTS = 600;
    localparam longint TIMEOUT_NS      = 64'd10_000_000;

    // Receiver ready pattern used in the periodic stall mode.
    localparam logic [7:0] STALL_PATTERN = 8'b1011_0110;

    typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_e;
    typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_BURSTY}
        stall_mode_e;

    // One rotated vector as it leaves the block.
    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          sat;
    } rotated_vec_t;

    // One row of the directed table. When known is set, the expected result is
    // the one typed in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic          known;
        rotated_vec_t  result;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [AW-1:0] phi;
        logic [AW-1:0] theta;
        logic [AW-1:0] psi;
    } stim_row_t;

    localparam rotated_vec_t ZERO_RESULT = '0;
    localparam int           N_DIRECTED  = 18;

    // Directed requests: zero vectors (whose result is zero whatever the
    // angles), full-scale vectors, every quadrant and the eighth-turn
    // boundaries, each of the three rotations alone, and vectors aligned so
    // that one component grows past full scale in both directions.
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b1, ZERO_RESULT, 24'h000000, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000},
        '{1'b1, ZERO_RESULT, 24'h000000, 24'h000000, 24'h000000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{1'b0, ZERO_RESULT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0000, 16'h0000, 16'h0000},
        '{1'b0, ZERO_RESULT, 24'h800000, 24'h800000, 24'h800000, 16'h0000, 16'h0000, 16'h0000},
        '{1'b0, ZERO_RESULT, 24'h7FFFFF, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h4000},
        '{1'b0, ZERO_RESULT, 24'h7FFFFF, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h8000},
        '{1'b0, ZERO_RESULT, 24'h7FFFFF, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'hC000},
        '{1'b0, ZERO_RESULT, 24'h800000, 24'h7FFFFF, 24'h000000, 16'h0000, 16'h0000, 16'h2000},
        '{1'b0, ZERO_RESULT, 24'h01E240, 24'hFE1DC0, 24'h000000, 16'h0000, 16'h0000, 16'h1FFF},
        '{1'b0, ZERO_RESULT, 24'h000000, 24'h000000, 24'h7FFFFF, 16'h0000, 16'h4000, 16'h0000},
        '{1'b0, ZERO_RESULT, 24'h7FFFFF, 24'h000000, 24'h800000, 16'h0000, 16'hE000, 16'h0000},
        '{1'b0, ZERO_RESULT, 24'h000000, 24'h7FFFFF, 24'h000000, 16'h6000, 16'h0000, 16'h0000},
        '{1'b0, ZERO_RESULT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0000, 16'h1913, 16'hE000},
        '{1'b0, ZERO_RESULT, 24'h800000, 24'h800000, 24'h800000, 16'h0000, 16'h1913, 16'hE000},
        '{1'b0, ZERO_RESULT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h8000, 16'h1913, 16'hE000},
        '{1'b0, ZERO_RESULT, 24'h555555, 24'hAAAAAA, 24'h5A5A5A, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{1'b0, ZERO_RESULT, 24'h000001, 24'hFFFFFF, 24'h000001, 16'h0001, 16'h0001, 16'h0001},
        '{1'b0, ZERO_RESULT, 24'h7FFFFF, 24'h800000, 24'h000000, 16'hA5A5, 16'h5A5A, 16'h3C3C}
    };

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [119:0]   s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [71:0]    m_axis_tdata;
    logic [0:0]     m_axis_tuser;

    // The typed expectation travels beside the request it belongs to.
    logic           req_known = 1'b0;
    rotated_vec_t   req_known_result = '0;

    rotated_vec_t   expected_q [$];
    int             fail_count = 0;

    // Receiver stall state.
    int             stall_cycle = 0;
    stall_mode_e    stall_mode = READY_ALWAYS;
    int             hold_left = 0;
    logic           hold_level = 1'b0;

    // Sender burst state.
    int             burst_left = 0;

    euler_zyz_vector_rotation u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Multiply by the CORDIC gain constant in Q0.32, rounding the magnitude
    // half away from zero. The split into high and low words keeps every
    // partial product inside 64 bits.
    function automatic longint apply_gain(input longint v);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        logic [63:0] g;
        begin
            g   = 64'(ezr_pkg::GAIN_Q32);
            neg = (v < 0);
            mag = neg ? 64'(-v) : 64'(v);
            hi  = mag >> 32;
            lo  = mag & 64'h0000_0000_FFFF_FFFF;
            r   = hi * g + ((lo * g + 64'h8000_0000) >> 32);
            return neg ? -longint'(r) : longint'(r);
        end
    endfunction

    // Rotate (u, v) counter-clockwise by a binary angle: a quarter-turn
    // pre-rotation brings the residual into [-1/8, 1/8) turn, then the CORDIC
    // stages remove it and the gain is compensated.
    function automatic void cordic_turn(inout longint u, inout longint v,
                                        input logic [AW-1:0] angle);
        logic [31:0] a;
        quadrant_e   quad;
        longint      resid;
        longint      t;
        longint      du;
        longint      dv;
        begin
            a     = 32'(angle) << (32 - AW);
            quad  = quadrant_e'(a[31:30]);
            resid = longint'(a & 32'h3FFF_FFFF);
            if (resid >= EIGHTH_TURN)
            begin
                resid = resid - QUARTER_TURN;
                quad  = quadrant_e'(2'(quad + 2'd1));
            end
            case (quad)
                QUAD_90:
                begin
                    t = u; u = -v; v = t;
                end
                QUAD_180:
                begin
                    u = -u; v = -v;
                end
                QUAD_270:
                begin
                    t = u; u = v; v = -t;
                end
                default: ;
            endcase
            for (int i = 0; i < ezr_pkg::CORDIC_STAGES; i++)
            begin
                du = v >>> i;
                dv = u >>> i;
                if (resid >= 0)
                begin
                    u = u - du;
                    v = v + dv;
                    resid = resid - longint'(ezr_pkg::ATAN_TURN[i]);
                end
                else
                begin
                    u = u + du;
                    v = v - dv;
                    resid = resid + longint'(ezr_pkg::ATAN_TURN[i]);
                end
            end
            u = apply_gain(u);
            v = apply_gain(v);
        end
    endfunction

    // Drop the guard fraction (round half up) and clip to the coordinate range.
    function automatic logic [CW-1:0] round_clip(input longint v, inout logic clip);
        longint r;
        begin
            r = (v + HALF_LSB) >>> ezr_pkg::GUARD_BITS;
            if (r > COORD_MAX)
            begin
                r    = COORD_MAX;
                clip = 1'b1;
            end
            if (r < COORD_MIN)
            begin
                r    = COORD_MIN;
                clip = 1'b1;
            end
            return CW'(r);
        end
    endfunction

    // Full Z-Y-Z rotation of one request: psi about Z, theta about Y (the pair
    // is (z, x) there), then phi about Z.
    function automatic rotated_vec_t predict_rotation(input logic [119:0] req);
        longint       x;
        longint       y;
        longint       z;
        logic         clip;
        rotated_vec_t res;
        begin
            x    = longint'($signed(req[23:0]))  * (64'sd1 <<< ezr_pkg::GUARD_BITS);
            y    = longint'($signed(req[47:24])) * (64'sd1 <<< ezr_pkg::GUARD_BITS);
            z    = longint'($signed(req[71:48])) * (64'sd1 <<< ezr_pkg::GUARD_BITS);
            clip = 1'b0;
            cordic_turn(x, y, req[119:104]);
            cordic_turn(z, x, req[103:88]);
            cordic_turn(x, y, req[87:72]);
            res.x   = round_clip(x, clip);
            res.y   = round_clip(y, clip);
            res.z   = round_clip(z, clip);
            res.sat = clip;
            return res;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic check_field(input string field, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
        begin
            if (want !== got)
            begin
                fail_count++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, $signed(want), $signed(got));
            end
        end
    endtask

    // Both handshakes are sampled at the same rising edge as the block sees
    // them. Every accepted request queues its expectation; every accepted
    // result is compared with the oldest one.
    always @(posedge clk)
    begin : result_check
        rotated_vec_t want;
        rotated_vec_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(req_known ? req_known_result
                                               : predict_rotation(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[71:48],
                       m_axis_tuser[0]};
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result with no request outstanding, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out_x", want.x, got.x);
                    check_field("out_y", want.y, got.y);
                    check_field("out_z", want.z, got.z);
                    check_field("saturated", CW'(want.sat), CW'(got.sat));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: the ready pattern is redrawn at random from always ready, coin
    // tosses, a fixed periodic pattern and long random holds, so that stalls
    // land on every phase of the pipeline.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver_stall
        logic ready_next;
        stall_cycle++;
        if (stall_cycle % 200 == 0)
            stall_mode = stall_mode_e'($urandom_range(0, 3));
        case (stall_mode)
            READY_ALWAYS:  ready_next = 1'b1;
            READY_COIN:    ready_next = 1'($urandom_range(0, 1));
            READY_PATTERN: ready_next = STALL_PATTERN[stall_cycle % 8];
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_level = ~hold_level;
                    hold_left  = $urandom_range(1, 24);
                end
                hold_left--;
                ready_next = hold_level;
            end
        endcase
        m_axis_tready <= ready_next;
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Present one request and hold it until it is accepted. Requests go out in
    // bursts of random length; between bursts tvalid drops for a random gap.
    // A zero gap keeps tvalid high so back-to-back bursts merge.
    task automatic issue(input logic [119:0] data, input logic known,
                         input rotated_vec_t result);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 12);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= {4{30'($urandom)}};
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            s_axis_tvalid    <= 1'b1;
            s_axis_tdata     <= data;
            req_known        <= known;
            req_known_result <= result;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    // A component within 64k of positive or negative full scale.
    function automatic logic [CW-1:0] near_full_scale();
        begin
            if ($urandom_range(0, 1) != 0)
                return 24'h7FFFFF - 24'($urandom_range(0, 'hFFFF));
            return 24'h800000 + 24'($urandom_range(0, 'hFFFF));
        end
    endfunction

    // An angle within two steps of a multiple of an eighth turn, where the
    // quadrant selection changes.
    function automatic logic [AW-1:0] near_boundary_angle();
        begin
            return AW'($urandom_range(0, 7) * 'h2000 + $urandom_range(0, 4) - 2);
        end
    endfunction

    initial
    begin : stimulus
        int            kind;
        logic [CW-1:0] vx;
        logic [CW-1:0] vy;
        logic [CW-1:0] vz;
        logic [AW-1:0] ang_phi;
        logic [AW-1:0] ang_theta;
        logic [AW-1:0] ang_psi;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
            issue({DIRECTED_ROWS[r].psi, DIRECTED_ROWS[r].theta, DIRECTED_ROWS[r].phi,
                   DIRECTED_ROWS[r].z, DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].x},
                  DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].result);

        // Random requests: half fully random, the rest weighted toward large
        // vectors (clipping), small vectors (rounding), angles at quadrant
        // edges and single-axis rotations.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            kind      = $urandom_range(0, 9);
            vx        = CW'($urandom);
            vy        = CW'($urandom);
            vz        = CW'($urandom);
            ang_phi   = AW'($urandom);
            ang_theta = AW'($urandom);
            ang_psi   = AW'($urandom);
            if (kind == 5 || kind == 6)
            begin
                vx = near_full_scale();
                vy = near_full_scale();
                vz = near_full_scale();
            end
            else if (kind == 7)
            begin
                vx = CW'(int'($urandom_range(0, 2000)) - 1000);
                vy = CW'(int'($urandom_range(0, 2000)) - 1000);
                vz = CW'(int'($urandom_range(0, 2000)) - 1000);
            end
            else if (kind == 8)
            begin
                ang_phi   = near_boundary_angle();
                ang_theta = near_boundary_angle();
                ang_psi   = near_boundary_angle();
            end
            else if (kind == 9)
            begin
                case ($urandom_range(0, 2))
                    0:       begin ang_theta = '0; ang_psi = '0; end
                    1:       begin ang_phi = '0; ang_psi = '0; end
                    default: begin ang_phi = '0; ang_theta = '0; end
                endcase
            end
            issue({ang_psi, ang_theta, ang_phi, vz, vy, vx}, 1'b0, ZERO_RESULT);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        // Any stray result after the drain is caught by the checker.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
